### hdl/assert_macros.svh
// Assertion macros used by the adapter port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CUBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cuba: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CUBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cuba: next-cycle check failed");

`endif

### hdl/cuba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell usage adapter package
// Shared widths, codes and structs of the cell usage bandwidth adapter.
// ----------------------------------------------------------------------------
package cuba_pkg;

    localparam int USED_WIDTH = 16;
    localparam int CNT_W      = 8;
    localparam int ELA_W      = 9;
    localparam int USED_IN_W  = 16;
    localparam int USED_SUM_W = ((USED_WIDTH > USED_IN_W) ? USED_WIDTH : USED_IN_W) + 1;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        OP_RESET    = 3'd0,
        OP_TICK     = 3'd1,
        OP_PEER     = 3'd2,
        OP_TX_USED  = 3'd3,
        OP_RX_USED  = 3'd4,
        OP_RX_LINK  = 3'd5,
        OP_ADD      = 3'd6,
        OP_DELETE   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        REQ_NONE    = 3'd0,
        REQ_ADD_TX  = 3'd1,
        REQ_ADD_RX  = 3'd2,
        REQ_DEL_TX  = 3'd3,
        REQ_DEL_RX  = 3'd4,
        REQ_COUNT   = 3'd5
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW      = 3'd0,
        CFG_USED_HIGH   = 3'd1,
        CFG_USED_LOW    = 3'd2,
        CFG_INIT_RX_HI  = 3'd3,
        CFG_MAX_TX      = 3'd4,
        CFG_MAX_RX      = 3'd5
    } cfg_idx_t;

    localparam logic [CNT_W-1:0] WINDOW_RST    = 8'd100;
    localparam logic [CNT_W-1:0] USED_HIGH_RST = 8'd75;
    localparam logic [CNT_W-1:0] USED_LOW_RST  = 8'd25;
    localparam logic [CNT_W-1:0] INIT_RX_RST   = 8'd75;
    localparam logic [CNT_W-1:0] MAX_CELLS_RST = 8'd8;

    // Limits that steer one direction's window evaluation
    typedef struct packed {
        logic [CNT_W-1:0] window;
        logic [CNT_W-1:0] high;
        logic [CNT_W-1:0] low;
        logic [CNT_W-1:0] max_cells;
        logic [CNT_W-1:0] least;
    } win_lim_t;

    // Outcome of one direction's tick
    typedef struct packed {
        logic [CNT_W-1:0] required;
        logic [ELA_W-1:0] elapsed;
        logic             clear_used;
        logic             idle;
    } win_res_t;

    // One input event as held in the input register
    typedef struct packed {
        op_t              opcode;
        logic             parent_present;
        logic [CNT_W-1:0] tx_now_scheduled;
        logic [CNT_W-1:0] rx_now_scheduled;
        logic             rx_conflicted;
        logic             clear_required;
        logic             cell_kind;
        logic [CNT_W-1:0] delta;
        logic             peer_is_parent;
        logic [USED_IN_W-1:0] used_count;
    } evt_t;

endpackage

### hdl/cuba_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one adapter event per transfer.
// ----------------------------------------------------------------------------
interface cuba_in_if import cuba_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [2:0]             opcode;
    logic                   parent_present;
    logic [CNT_W-1:0]       tx_now_scheduled;
    logic [CNT_W-1:0]       rx_now_scheduled;
    logic                   rx_conflicted;
    logic                   clear_required;
    logic                   cell_kind;
    logic signed [CNT_W-1:0] delta;
    logic                   peer_is_parent;
    logic [USED_IN_W-1:0]   used_count;

    modport source (
        output valid, opcode, parent_present, tx_now_scheduled, rx_now_scheduled,
               rx_conflicted, clear_required, cell_kind, delta, peer_is_parent,
               used_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, parent_present, tx_now_scheduled, rx_now_scheduled,
               rx_conflicted, clear_required, cell_kind, delta, peer_is_parent,
               used_count,
        output ready
    );
endinterface

### hdl/cuba_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one adapter result per transfer.
// ----------------------------------------------------------------------------
interface cuba_out_if import cuba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       request_kind;
    logic             link_granted;
    logic [CNT_W-1:0] tx_required_out;
    logic [CNT_W-1:0] rx_required_out;
    logic [CNT_W-1:0] tx_scheduled_out;
    logic [CNT_W-1:0] rx_scheduled_out;
    logic             keep_alive_pending;

    modport source (
        output valid, request_kind, link_granted, tx_required_out, rx_required_out,
               tx_scheduled_out, rx_scheduled_out, keep_alive_pending,
        input  ready
    );
    modport sink (
        input  valid, request_kind, link_granted, tx_required_out, rx_required_out,
               tx_scheduled_out, rx_scheduled_out, keep_alive_pending,
        output ready
    );
endinterface

### hdl/cuba_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register write: index and 8-bit data per transfer.
// ----------------------------------------------------------------------------
interface cuba_cfg_if import cuba_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### hdl/cuba_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Usage window evaluator
// One direction's tick: grow elapsed, close the window, adjust required.
// ----------------------------------------------------------------------------
module cuba_window import cuba_pkg::*; (
    input  logic [CNT_W-1:0]      sched,
    input  logic [ELA_W-1:0]      inc,
    input  logic [ELA_W-1:0]      elapsed,
    input  logic [USED_WIDTH-1:0] used,
    input  logic [CNT_W-1:0]      required,
    input  win_lim_t              lim,
    output win_res_t              res
);

    logic [ELA_W-1:0] ela_sum;
    logic             closes;
    logic             over;
    logic             under;

    assign ela_sum = elapsed + inc;
    assign closes  = ela_sum >= ELA_W'(lim.window);
    assign over    = used > USED_WIDTH'(lim.high);
    assign under   = used < USED_WIDTH'(lim.low);

    always_comb
    begin
        res.required   = required;
        res.elapsed    = closes ? '0 : ela_sum;
        res.clear_used = closes;
        res.idle       = closes && !over && under && (used == '0) && (sched != '0);
        if (closes && over)
        begin
            // required < sched + 1, with sched below max so no overflow
            if ((sched < lim.max_cells) && (required <= sched))
                res.required = sched + CNT_W'(1);
        end
        else if (closes && under)
        begin
            // sched > least keeps sched - 1 from wrapping
            if ((sched > lim.least) && (required >= sched))
                res.required = sched - CNT_W'(1);
        end
    end

endmodule

### hdl/cell_usage_bandwidth_adapter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell usage bandwidth adapter
// Per-direction TX/RX cell usage tracking and add/delete request decisions.
// ----------------------------------------------------------------------------
// One event is taken every clock cycle while the result side does not stall.
// An event passes an input register, one pass of combinational logic (the
// two per-direction window evaluators and the opcode decode) that updates the
// count registers, and a result register that is loaded as the input stage
// advances. The result register holds a stalled result while the next event
// is already taken; a stall on the result side backs up one event deep before
// ready drops.
// Configuration writes are taken in every cycle.
module cell_usage_bandwidth_adapter import cuba_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    cuba_in_if.sink    evt,
    cuba_out_if.source res,
    cuba_cfg_if.sink   cfg
);

    localparam logic [USED_WIDTH-1:0] USED_MAX = {USED_WIDTH{1'b1}};

    // configuration
    logic [CNT_W-1:0] window_reg, used_high_reg, used_low_reg;
    logic [CNT_W-1:0] init_rx_hi_reg, max_tx_reg, max_rx_reg;

    // input stage
    logic s1_valid_reg;
    evt_t s1_reg;
    logic advance;

    // counts
    logic [CNT_W-1:0]      tx_sched_reg, tx_sched_next, rx_sched_reg, rx_sched_next;
    logic [CNT_W-1:0]      tx_req_reg, tx_req_next, rx_req_reg, rx_req_next;
    logic [ELA_W-1:0]      tx_ela_reg, tx_ela_next, rx_ela_reg, rx_ela_next;
    logic [USED_WIDTH-1:0] tx_used_reg, tx_used_next, rx_used_reg, rx_used_next;
    logic                  ka_reg, ka_next;

    // result stage
    logic             res_valid_reg;
    req_kind_t        kind_reg, kind_next;
    logic             granted_reg, granted_next;
    logic [CNT_W-1:0] tx_req_out_reg, rx_req_out_reg, tx_sch_out_reg, rx_sch_out_reg;
    logic             ka_out_reg;

    // window evaluation
    win_lim_t         tx_lim, rx_lim;
    win_res_t         tx_win, rx_win;
    logic [ELA_W-1:0] rx_inc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= WINDOW_RST;
            used_high_reg  <= USED_HIGH_RST;
            used_low_reg   <= USED_LOW_RST;
            init_rx_hi_reg <= INIT_RX_RST;
            max_tx_reg     <= MAX_CELLS_RST;
            max_rx_reg     <= MAX_CELLS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WINDOW:     window_reg     <= cfg.data;
                CFG_USED_HIGH:  used_high_reg  <= cfg.data;
                CFG_USED_LOW:   used_low_reg   <= cfg.data;
                CFG_INIT_RX_HI: init_rx_hi_reg <= cfg.data;
                CFG_MAX_TX:     max_tx_reg     <= cfg.data;
                CFG_MAX_RX:     max_rx_reg     <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Advance the input stage whenever the result register is free or drains.
    assign advance   = s1_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (evt.valid && evt.ready)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            s1_reg.opcode           <= op_t'(evt.opcode);
            s1_reg.parent_present   <= evt.parent_present;
            s1_reg.tx_now_scheduled <= evt.tx_now_scheduled;
            s1_reg.rx_now_scheduled <= evt.rx_now_scheduled;
            s1_reg.rx_conflicted    <= evt.rx_conflicted;
            s1_reg.clear_required   <= evt.clear_required;
            s1_reg.cell_kind        <= evt.cell_kind;
            s1_reg.delta            <= evt.delta;
            s1_reg.peer_is_parent   <= evt.peer_is_parent;
            s1_reg.used_count       <= evt.used_count;
        end
    end

    // RX high limit follows the scheduled count before the tick loads it.
    always_comb
    begin
        tx_lim.window    = window_reg;
        tx_lim.high      = used_high_reg;
        tx_lim.low       = used_low_reg;
        tx_lim.max_cells = max_tx_reg;
        tx_lim.least     = CNT_W'(1);
        rx_lim.window    = window_reg;
        rx_lim.high      = (rx_sched_reg == '0) ? init_rx_hi_reg : used_high_reg;
        rx_lim.low       = used_low_reg;
        rx_lim.max_cells = max_rx_reg;
        rx_lim.least     = CNT_W'(s1_reg.rx_conflicted);
    end

    // Idle RX link still counts one cell per tick unless conflicted.
    assign rx_inc = (s1_reg.rx_now_scheduled == '0) ? ELA_W'(!s1_reg.rx_conflicted)
                                                    : ELA_W'(s1_reg.rx_now_scheduled);

    cuba_window u_tx_win (
        .sched    (s1_reg.tx_now_scheduled),
        .inc      (ELA_W'(s1_reg.tx_now_scheduled)),
        .elapsed  (tx_ela_reg),
        .used     (tx_used_reg),
        .required (tx_req_reg),
        .lim      (tx_lim),
        .res      (tx_win)
    );

    cuba_window u_rx_win (
        .sched    (s1_reg.rx_now_scheduled),
        .inc      (rx_inc),
        .elapsed  (rx_ela_reg),
        .used     (rx_used_reg),
        .required (rx_req_reg),
        .lim      (rx_lim),
        .res      (rx_win)
    );

    always_comb
    begin
        logic [CNT_W-1:0]      sch;
        logic [CNT_W:0]        mag;
        logic [CNT_W:0]        up_sum;
        logic [USED_SUM_W-1:0] used_sum;

        tx_sched_next = tx_sched_reg;
        rx_sched_next = rx_sched_reg;
        tx_req_next   = tx_req_reg;
        rx_req_next   = rx_req_reg;
        tx_ela_next   = tx_ela_reg;
        rx_ela_next   = rx_ela_reg;
        tx_used_next  = tx_used_reg;
        rx_used_next  = rx_used_reg;
        ka_next       = ka_reg;
        kind_next     = REQ_NONE;
        granted_next  = 1'b0;

        sch      = s1_reg.cell_kind ? rx_sched_reg : tx_sched_reg;
        mag      = (CNT_W+1)'(256) - {1'b0, s1_reg.delta};
        up_sum   = {1'b0, sch} + {1'b0, s1_reg.delta};
        used_sum = USED_SUM_W'(tx_used_reg) + USED_SUM_W'(s1_reg.used_count);

        case (s1_reg.opcode)
            OP_RESET:
            begin
                ka_next       = 1'b0;
                tx_sched_next = '0;
                rx_sched_next = '0;
                tx_ela_next   = '0;
                rx_ela_next   = '0;
                tx_used_next  = '0;
                rx_used_next  = '0;
                if (s1_reg.clear_required)
                begin
                    tx_req_next = CNT_W'(1);
                    rx_req_next = CNT_W'(s1_reg.rx_conflicted);
                end
                if (s1_reg.parent_present)
                begin
                    tx_sched_next = s1_reg.tx_now_scheduled;
                    rx_sched_next = s1_reg.rx_now_scheduled;
                end
            end
            OP_TICK:
            begin
                if (s1_reg.parent_present)
                begin
                    tx_sched_next = s1_reg.tx_now_scheduled;
                    tx_ela_next   = tx_win.elapsed;
                    tx_req_next   = tx_win.required;
                    if (tx_win.clear_used)
                        tx_used_next = '0;
                    if (tx_win.idle)
                        ka_next = 1'b1;
                    rx_sched_next = s1_reg.rx_now_scheduled;
                    rx_ela_next   = rx_win.elapsed;
                    rx_req_next   = rx_win.required;
                    if (rx_win.clear_used)
                        rx_used_next = '0;
                end
            end
            OP_PEER:
            begin
                if ((s1_reg.delta != '0) && s1_reg.parent_present && s1_reg.peer_is_parent)
                begin
                    if (s1_reg.delta[CNT_W-1])
                    begin
                        // drop the change if it would go below zero
                        if ({1'b0, sch} >= mag)
                            sch = sch - mag[CNT_W-1:0];
                    end
                    else
                    begin
                        sch = up_sum[CNT_W] ? {CNT_W{1'b1}} : up_sum[CNT_W-1:0];
                    end
                    if (s1_reg.cell_kind)
                        rx_sched_next = sch;
                    else
                        tx_sched_next = sch;
                end
            end
            OP_TX_USED:
            begin
                if (used_sum > USED_SUM_W'(USED_MAX))
                    tx_used_next = USED_MAX;
                else
                    tx_used_next = used_sum[USED_WIDTH-1:0];
            end
            OP_RX_USED:
            begin
                if (rx_used_reg != USED_MAX)
                    rx_used_next = rx_used_reg + USED_WIDTH'(1);
            end
            OP_RX_LINK:
            begin
                if (rx_req_reg == '0)
                begin
                    rx_req_next  = CNT_W'(1);
                    granted_next = 1'b1;
                end
            end
            OP_ADD:
            begin
                if (s1_reg.rx_conflicted && (rx_sched_reg == '0))
                    kind_next = REQ_ADD_RX;
                else if (tx_sched_reg < tx_req_reg)
                    kind_next = REQ_ADD_TX;
                else if (rx_sched_reg < rx_req_reg)
                    kind_next = REQ_ADD_RX;
            end
            OP_DELETE:
            begin
                if (tx_sched_reg > tx_req_reg)
                    kind_next = REQ_DEL_TX;
                else if (rx_sched_reg > rx_req_reg)
                    kind_next = REQ_DEL_RX;
                else if (ka_reg)
                begin
                    kind_next = REQ_COUNT;
                    ka_next   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_sched_reg <= '0;
            rx_sched_reg <= '0;
            tx_req_reg   <= '0;
            rx_req_reg   <= '0;
            tx_ela_reg   <= '0;
            rx_ela_reg   <= '0;
            tx_used_reg  <= '0;
            rx_used_reg  <= '0;
            ka_reg       <= 1'b0;
        end
        else if (advance)
        begin
            tx_sched_reg <= tx_sched_next;
            rx_sched_reg <= rx_sched_next;
            tx_req_reg   <= tx_req_next;
            rx_req_reg   <= rx_req_next;
            tx_ela_reg   <= tx_ela_next;
            rx_ela_reg   <= rx_ela_next;
            tx_used_reg  <= tx_used_next;
            rx_used_reg  <= rx_used_next;
            ka_reg       <= ka_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg       <= kind_next;
            granted_reg    <= granted_next;
            tx_req_out_reg <= tx_req_next;
            rx_req_out_reg <= rx_req_next;
            tx_sch_out_reg <= tx_sched_next;
            rx_sch_out_reg <= rx_sched_next;
            ka_out_reg     <= ka_next;
        end
    end

    assign res.valid              = res_valid_reg;
    assign res.request_kind       = kind_reg;
    assign res.link_granted       = granted_reg;
    assign res.tx_required_out    = tx_req_out_reg;
    assign res.rx_required_out    = rx_req_out_reg;
    assign res.tx_scheduled_out   = tx_sch_out_reg;
    assign res.rx_scheduled_out   = rx_sch_out_reg;
    assign res.keep_alive_pending = ka_out_reg;

endmodule

### hdl/cuba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adapter port checker
// Checks on the result port of the cell usage bandwidth adapter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cuba_checker import cuba_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [2:0]       request_kind,
    input logic             link_granted,
    input logic [CNT_W-1:0] tx_required_out,
    input logic [CNT_W-1:0] rx_required_out,
    input logic [CNT_W-1:0] tx_scheduled_out,
    input logic [CNT_W-1:0] rx_scheduled_out,
    input logic             keep_alive_pending
);

    // a stalled result holds
    `CUBA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(request_kind) && $stable(tx_required_out) && $stable(rx_required_out) && $stable(keep_alive_pending))

    // a granted link leaves exactly one RX cell required
    `CUBA_ASSERT_IMP(a_grant_req, clk, rst_n, out_valid && link_granted, rx_required_out == CNT_W'(1))

    // a delete TX request only with a TX surplus
    `CUBA_ASSERT_IMP(a_del_tx, clk, rst_n, out_valid && (request_kind == REQ_DEL_TX), tx_scheduled_out > tx_required_out)

    // a count request consumes the keep-alive
    `CUBA_ASSERT_IMP(a_count_ka, clk, rst_n, out_valid && (request_kind == REQ_COUNT), !keep_alive_pending)

endmodule

bind cell_usage_bandwidth_adapter cuba_checker u_cuba_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (res.valid),
    .out_ready          (res.ready),
    .request_kind       (res.request_kind),
    .link_granted       (res.link_granted),
    .tx_required_out    (res.tx_required_out),
    .rx_required_out    (res.rx_required_out),
    .tx_scheduled_out   (res.tx_scheduled_out),
    .rx_scheduled_out   (res.rx_scheduled_out),
    .keep_alive_pending (res.keep_alive_pending)
);
